// ----- rtl/core/tts_pkg.sv -----
// Package for the tridiagonal solver: request types, state codes, saturation helpers.
// Used by tridiagonal_thomas_solver; depends on nothing.
package tts_pkg;

  localparam int MAX_ROWS_DEF  = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic signed [31:0] sub_diag;
    logic signed [31:0] main_diag;
    logic signed [31:0] super_diag;
    logic signed [31:0] rhs;
    logic               last_row;
  } row_t;

  typedef struct packed {
    logic signed [31:0] solution;
    logic               final_res;
    logic               singular;
  } res_t;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MUL1  = 12'b000000000010,
    S_MUL2  = 12'b000000000100,
    S_DIV   = 12'b000000001000,
    S_WRITE = 12'b000000010000,
    S_BRD   = 12'b000000100000,
    S_BMUL  = 12'b000001000000,
    S_BADD  = 12'b000010000000,
    S_EHEAD = 12'b000100000000,
    S_ERD   = 12'b001000000000,
    S_EOUT  = 12'b010000000000,
    S_ETAIL = 12'b100000000000
  } state_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/tts_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the per-row coefficient stores.
module tts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/tridiagonal_thomas_solver.sv -----
// Tridiagonal solver: forward sweep per row, back substitution, ascending emission.
// Depends on tts_pkg and tts_ram.
// A row request runs the forward sweep in Q16.16 by default, with the shared radix-2
// divider running gamma then beta; the last row runs beta only, and a zero pivot row
// skips the divider. The last row then adds back substitution and n+2 results; a new
// row is held off by row_stall until the run returns to idle, and results wait on res_stall.
// Synchronous reset clears the run state; the stores are not cleared.
module tridiagonal_thomas_solver
  import tts_pkg::*;
#(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic row_valid,
  output logic row_stall,
  input  row_t row,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DW = 33 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam logic [DW-1:0] QHALF = DW'(1) << 31;

  state_t state;
  logic [AW-1:0] row_count, idx, k, e;
  logic lastr, fault, div_beta, dneg;
  logic signed [31:0] a, b, c, d, pg, pb, denom, num, g, be, x, bq;
  logic signed [63:0] mul_p;
  logic [DW-1:0] qr;
  logic [32:0] rem, qm;
  logic [CW-1:0] cnt;

  logic g_we, b_we;
  logic [AW-1:0] b_waddr, raddr;
  logic signed [31:0] b_wdata, g_rdata, b_rdata;
  logic signed [31:0] fprod, denom_now, num_now, xnew, qsat;
  logic signed [32:0] negc, load_n;
  logic [32:0] load_mag, t;
  logic [33:0] tsub;
  logic slot_free, cap, res_load;

  assign row_stall = (state != S_IDLE);
  assign slot_free = !res_valid || !res_stall;
  assign res_load = slot_free && (state inside {S_EHEAD, S_EOUT, S_ETAIL});
  assign cap = ({1'b0, row_count} >= (AW + 1)'(MAX_ROWS - 1));

  always_comb begin
    fprod = sat64(mul_p >>> FRAC_BITS);
    denom_now = sat33({fprod[31], fprod} + {b[31], b});
    num_now = sat33({d[31], d} - {fprod[31], fprod});
    xnew = sat33({fprod[31], fprod} + {bq[31], bq});
    negc = -{c[31], c};
    if (state == S_MUL2) begin
      load_n = lastr ? {num_now[31], num_now} : negc;
    end else begin
      load_n = {num[31], num};
    end
    load_mag = load_n[32] ? 33'(-load_n) : 33'(load_n);
    t = {rem[31:0], qr[DW-1]};
    tsub = {1'b0, t} - {1'b0, qm};
    if (dneg) begin
      qsat = (qr > QHALF) ? 32'sh80000000 : 32'(-qr);
    end else begin
      qsat = (qr > QHALF - DW'(1)) ? 32'sh7fffffff : qr[31:0];
    end
  end

  assign g_we = (state == S_WRITE);
  assign b_we = (state == S_WRITE) || (state == S_BADD);
  assign b_waddr = (state == S_WRITE) ? idx : k - AW'(1);
  assign b_wdata = (state == S_WRITE) ? be : xnew;
  assign raddr = (state == S_BRD) ? k - AW'(1) : e;

  tts_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_gamma (
    .clk(clk), .we(g_we), .waddr(idx), .wdata(g), .raddr(raddr), .rdata(g_rdata)
  );

  tts_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_beta (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(raddr), .rdata(b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row_count <= '0;
      pg <= '0;
      pb <= '0;
      fault <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && !res_load) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (row_valid) begin
            a <= row.sub_diag;
            b <= row.main_diag;
            c <= row.super_diag;
            d <= row.rhs;
            idx <= cap ? AW'(MAX_ROWS - 1) : row_count;
            lastr <= row.last_row | cap;
            mul_p <= row.sub_diag * pg;
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          denom <= denom_now;
          mul_p <= a * pb;
          state <= S_MUL2;
        end
        S_MUL2: begin
          num <= num_now;
          if (denom == 32'sd0) begin
            fault <= 1'b1;
            g <= '0;
            be <= '0;
            state <= S_WRITE;
          end else begin
            if (lastr) begin
              g <= '0;
            end
            div_beta <= lastr;
            qr <= {load_mag, FRAC_BITS'(0)};
            rem <= '0;
            qm <= denom[31] ? 33'(-{denom[31], denom}) : 33'({denom[31], denom});
            dneg <= load_n[32] ^ denom[31];
            cnt <= CW'(DW);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt != '0) begin
            if (!tsub[33]) begin
              rem <= tsub[32:0];
              qr <= {qr[DW-2:0], 1'b1};
            end else begin
              rem <= t;
              qr <= {qr[DW-2:0], 1'b0};
            end
            cnt <= cnt - CW'(1);
          end else if (!div_beta) begin
            g <= qsat;
            div_beta <= 1'b1;
            qr <= {load_mag, FRAC_BITS'(0)};
            rem <= '0;
            dneg <= load_n[32] ^ denom[31];
            cnt <= CW'(DW);
          end else begin
            be <= qsat;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          pg <= g;
          pb <= be;
          if (!lastr) begin
            row_count <= idx + AW'(1);
            state <= S_IDLE;
          end else begin
            x <= be;
            k <= idx;
            state <= (idx == '0) ? S_EHEAD : S_BRD;
          end
        end
        S_BRD: begin
          state <= S_BMUL;
        end
        S_BMUL: begin
          mul_p <= g_rdata * x;
          bq <= b_rdata;
          state <= S_BADD;
        end
        S_BADD: begin
          x <= xnew;
          k <= k - AW'(1);
          state <= (k == AW'(1)) ? S_EHEAD : S_BRD;
        end
        S_EHEAD: begin
          if (slot_free) begin
            res <= '{solution: 32'sd0, final_res: 1'b0, singular: fault};
            res_valid <= 1'b1;
            e <= '0;
            state <= S_ERD;
          end
        end
        S_ERD: begin
          state <= S_EOUT;
        end
        S_EOUT: begin
          if (slot_free) begin
            res <= '{solution: b_rdata, final_res: 1'b0, singular: fault};
            res_valid <= 1'b1;
            if (e == idx) begin
              state <= S_ETAIL;
            end else begin
              e <= e + AW'(1);
              state <= S_ERD;
            end
          end
        end
        S_ETAIL: begin
          if (slot_free) begin
            res <= '{solution: 32'sd0, final_res: 1'b1, singular: fault};
            res_valid <= 1'b1;
            pg <= '0;
            pb <= '0;
            row_count <= '0;
            fault <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_gamma_write: assert property (@(posedge clk) disable iff (rst)
    g_we |-> (state == S_WRITE))
    else $error("gamma store written outside the row write step");

  a_back_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_BRD) |-> (k != '0))
    else $error("back substitution read with zero row index");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result changed or dropped");

endmodule

// ----- tb/testbench.sv -----
// Testbench for tridiagonal_thomas_solver: streams tridiagonal systems row by row and
// checks every emitted solution element against a fixed-point Thomas-sweep predictor.
// Depends on tts_pkg and the solver RTL only.
`timescale 1ns / 100ps

module testbench
  import tts_pkg::*;
;

  localparam int MAXR = MAX_ROWS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int HOLD_LEN = 600;

  logic clk;
  logic rst;
  logic row_valid;
  logic row_stall;
  row_t row;
  logic res_valid;
  logic res_stall;
  res_t res;

  res_t solution_queue[$];
  longint gamma_mem[MAXR];
  longint beta_mem[MAXR];
  longint carry_gamma;
  longint carry_beta;
  int rows_held;
  bit pivot_zero;
  int errors = 0;
  longint cycles = 0;
  int hold_cycles;
  int hold_req = 0;
  int hold_seen;
  bit quiet_out;
  bit row_up;

  tridiagonal_thomas_solver u_top (
    .clk(clk), .rst(rst), .row_valid(row_valid), .row_stall(row_stall), .row(row),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint p, longint q);
    return clamp32((p * q) >>> FB);
  endfunction

  function automatic longint qdiv(longint n, longint q);
    return clamp32((n * (64'sd1 <<< FB)) / q);
  endfunction

  task automatic sweep_row(row_t r);
    longint a, b, c, d, den, num, g, be, x;
    int idx, n;
    bit fin;
    res_t e;
    a = longint'(r.sub_diag);
    b = longint'(r.main_diag);
    c = longint'(r.super_diag);
    d = longint'(r.rhs);
    fin = r.last_row;
    idx = rows_held;
    if (idx >= MAXR - 1) begin
      idx = MAXR - 1;
      fin = 1;
    end
    den = clamp32(qmul(a, carry_gamma) + b);
    num = clamp32(d - qmul(a, carry_beta));
    if (den == 0) begin
      pivot_zero = 1;
      g = 0;
      be = 0;
    end else begin
      g = fin ? 0 : qdiv(-c, den);
      be = qdiv(num, den);
    end
    gamma_mem[idx] = g;
    beta_mem[idx] = be;
    carry_gamma = g;
    carry_beta = be;
    if (!fin) begin
      rows_held = idx + 1;
      return;
    end
    n = idx + 1;
    begin
      res_t body[$];
      x = beta_mem[n - 1];
      body.push_front('{solution: x[31:0], final_res: 0, singular: pivot_zero});
      for (int k = n - 1; k >= 1; k--) begin
        x = clamp32(qmul(gamma_mem[k - 1], x) + beta_mem[k - 1]);
        body.push_front('{solution: x[31:0], final_res: 0, singular: pivot_zero});
      end
      e = '{solution: 0, final_res: 0, singular: pivot_zero};
      solution_queue = {solution_queue, e};
      foreach (body[i]) solution_queue = {solution_queue, body[i]};
      e.final_res = 1;
      solution_queue = {solution_queue, e};
    end
    carry_gamma = 0;
    carry_beta = 0;
    rows_held = 0;
    pivot_zero = 0;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic release_rows();
    if (row_up) begin
      row_valid <= 0;
      row_up = 0;
      @(posedge clk);
    end
  endtask

  task automatic send_row(logic signed [31:0] a, logic signed [31:0] b,
                          logic signed [31:0] c, logic signed [31:0] d, logic fin);
    int g;
    row_valid <= 1;
    row_up = 1;
    row <= '{sub_diag: a, main_diag: b, super_diag: c, rhs: d, last_row: fin};
    @(posedge clk);
    while (row_stall) @(posedge clk);
    sweep_row('{sub_diag: a, main_diag: b, super_diag: c, rhs: d, last_row: fin});
    g = gap_len();
    if (g != 0) begin
      row_valid <= 0;
      row_up = 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    release_rows();
    while (solution_queue.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coef();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return $urandom();
    if (p == 1) return 32'sh80000000 >>> $urandom_range(0, 15);
    return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
  endfunction

  task automatic send_system(int n);
    for (int i = 0; i < n; i++)
      send_row(rand_coef(), $signed($urandom_range(0, 32'h0008_0000)) + 32'sh0004_0000,
               rand_coef(), rand_coef(), i == n - 1);
  endtask

  task automatic test_extremes();
    send_row(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1);
    send_row(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_row(32'sh80000000, 32'sh00000001, 32'sh80000000, 32'sh7fffffff, 0);
    send_row(32'sh7fffffff, 32'shffffffff, 32'sh00000000, 32'sh80000000, 1);
    send_row(32'sh00000000, 32'sh00010000, 32'sh00008000, 32'sh00020000, 0);
    send_row(32'sh00010000, 32'sh00040000, 32'sh00010000, 32'shfffe0000, 1);
    drain();
  endtask

  task automatic test_zero_pivot();
    send_row(32'sh00000000, 32'sh00000000, 32'sh00010000, 32'sh00050000, 0);
    send_row(32'sh00010000, 32'sh00020000, 32'sh00010000, 32'sh00010000, 1);
    send_row(32'sh00000000, 32'sh00010000, 32'sh00010000, 32'sh00010000, 0);
    send_row(32'sh00010000, 32'shffff0000, 32'sh00000000, 32'sh00010000, 1);
    drain();
  endtask

  task automatic test_overflow_rows();
    for (int i = 0; i < MAXR + 2; i++)
      send_row(32'sh00008000, 32'sh00030000, 32'shffff8000, $urandom(), 0);
    drain();
  endtask

  task automatic test_random_systems();
    int sent;
    sent = 0;
    while (sent < 95) begin
      int n, p;
      p = $urandom_range(0, 9);
      n = (p == 0) ? $urandom_range(20, MAXR) : $urandom_range(1, 5);
      if (p == 1) begin
        for (int i = 0; i < n; i++)
          send_row($urandom(), $urandom(), $urandom(), $urandom(), i == n - 1);
      end else begin
        send_system(n);
      end
      sent += n;
    end
    drain();
  endtask

  task automatic test_backpressure();
    quiet_out = 1;
    hold_req++;
    send_system(3);
    send_system(2);
    send_system(4);
    release_rows();
    wait (hold_seen == hold_req && hold_cycles == 0);
    quiet_out = 0;
    drain();
    send_system(2);
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 0;
      hold_cycles <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_cycles <= HOLD_LEN;
      res_stall <= 1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res_stall <= 1;
    end else if (quiet_out) begin
      res_stall <= 0;
    end else begin
      res_stall <= ($urandom_range(0, 99) < 30) ? 1'b1
                 : ($urandom_range(0, 99) < 3 ? 1'b1 : 1'b0);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (solution_queue.size() == 0) begin
        $error("unexpected result: solution %0d", res.solution);
        errors++;
      end else begin
        res_t e;
        e = solution_queue.pop_front();
        if (res.solution !== e.solution) begin
          $error("solution expected %0d actual %0d", e.solution, res.solution);
          errors++;
        end
        if (res.final_res !== e.final_res) begin
          $error("final_res expected %0d actual %0d", e.final_res, res.final_res);
          errors++;
        end
        if (res.singular !== e.singular) begin
          $error("singular expected %0d actual %0d", e.singular, res.singular);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1;
    row_valid = 0;
    row = '0;
    row_up = 0;
    quiet_out = 0;
    carry_gamma = 0;
    carry_beta = 0;
    rows_held = 0;
    pivot_zero = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_extremes();
    test_zero_pivot();
    test_overflow_rows();
    test_backpressure();
    test_random_systems();
    drain();
    repeat (300) @(posedge clk);
    if (errors == 0 && solution_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
